### rtl/core/bngct_pkg.sv
// Shared constants, types and address helpers for the byte n-gram counter table.
package bngct_pkg;

  localparam int unsigned ORDER_DEF   = 2;
  localparam int unsigned COUNT_W_DEF = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned IDX_W       = 17;
  localparam int unsigned CMP_W       = 32;
  localparam int unsigned OUT_W       = 32;
  localparam int unsigned WIDE_W      = 64;
  localparam int unsigned S_TDATA_W   = 32;
  localparam int unsigned M_TDATA_W   = 32;

  typedef struct packed {
    logic bump;
    logic clear;
  } bank_ctl_t;

  // First table address of the region that holds k-byte contexts (k = 0 is the total).
  function automatic logic [CMP_W-1:0] region_base(input int unsigned k);
    longint unsigned acc;
    longint unsigned w;
    acc = 0;
    w   = 1;
    for (int unsigned j = 0; j < k; j++) begin
      acc = acc + w;
      w   = w * 256;
    end
    return CMP_W'(acc);
  endfunction

endpackage

### rtl/core/byte_ngram_count_table.sv
// Top level of the byte n-gram counter table with stream request and result channels.
//
// Requests enter on s_axis: tuser selects push (0) or read (1). A push carries one byte
// and a stream start flag; once ORDER-1 earlier bytes of the stream are held, it adds
// one to the total and to one counter per context length. A read names a counter and
// returns it on m_axis, with tuser set and zero data when the index lies beyond the table.
// Pushes give no result.
// Throughput: one request per cycle while s_axis_tready is high, push or read in any mix.
// Each context length has its own memory bank with one read and one write port; a bump
// reads at acceptance, writes in the cycle after, and a back-to-back bump of the same
// entry takes the value from the forwarding register. The total count is a register.
// Read path: a read's select and bank data are registered, then the result is written into
// the two-entry output buffer, which drives m_axis.
// Reset: the banks are swept to zero one entry per cycle as a clear counter steps through
// all 256**ORDER values; s_axis_tready stays low until the sweep ends.
// Stalls: results queue in a two-entry output buffer; after the sweep, s_axis_tready drops
// only when that buffer and the read in flight would overfill it.
module byte_ngram_count_table import bngct_pkg::*; #(
  parameter int unsigned ORDER       = ORDER_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_W_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [0] stream_start, [8:1] data_byte, [25:9] read_index, [31:26] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] op
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] count_value
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [0] bad_index
  output logic                 m_axis_tuser
);

  localparam int unsigned HIST_N   = (ORDER > 1) ? ORDER - 1 : 1;
  localparam int unsigned CLR_W    = BYTE_W * ORDER;
  localparam logic [1:0]  FULL_LVL = 2'(ORDER - 1);

  logic               in_op;
  logic               in_start;
  logic [BYTE_W-1:0]  in_byte;
  logic [IDX_W-1:0]   in_idx;
  logic [CMP_W-1:0]   idx_ext;
  logic [ORDER:0]     in_sel;
  logic               in_bad;

  logic               accept;
  logic               push_acc;
  logic               bump;
  logic [1:0]         fill_eff;
  logic               win_full;
  logic [1:0]         fill_d;
  logic [1:0]         fill_q;
  logic [BYTE_W-1:0]  hist_q [HIST_N];

  logic               clearing_q;
  logic [CLR_W-1:0]   clr_cnt_q;
  logic [COUNT_WIDTH-1:0] total_q;
  bank_ctl_t          bank_ctl;
  logic [COUNT_WIDTH-1:0] bank_cnt [1:ORDER];

  logic               s1_rd_q;
  logic [ORDER:0]     s1_sel_q;
  logic               s1_bad_q;
  logic [COUNT_WIDTH-1:0] s1_total_q;
  logic [COUNT_WIDTH-1:0] res_cnt;
  logic [OUT_W-1:0]   res_val;

  logic [OUT_W-1:0]   fifo_data_q [2];
  logic               fifo_bad_q [2];
  logic               wr_ptr_q;
  logic               rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               fifo_push;
  logic               fifo_pop;
  logic [2:0]         level;

  assign in_op    = s_axis_tuser;
  assign in_start = s_axis_tdata[0];
  assign in_byte  = s_axis_tdata[8:1];
  assign in_idx   = s_axis_tdata[25:9];
  assign idx_ext  = CMP_W'(in_idx);

  assign fifo_push     = s1_rd_q;
  assign fifo_pop      = m_axis_tvalid & m_axis_tready;
  assign level         = 3'(cnt_q) + 3'(fifo_push) - 3'(fifo_pop);
  assign s_axis_tready = !clearing_q && (level < 3'd2);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign push_acc      = accept & !in_op;

  always_comb begin
    fill_eff = in_start ? 2'd0 : fill_q;
    win_full = (fill_eff >= FULL_LVL);
    fill_d   = win_full ? fill_eff : fill_eff + 2'd1;
    bump     = push_acc & win_full;
    in_sel[0] = (idx_ext == '0);
    for (int unsigned k = 1; k <= ORDER; k++) begin
      in_sel[k] = (idx_ext >= region_base(k)) && (idx_ext < region_base(k + 1));
    end
    in_bad    = (idx_ext >= region_base(ORDER + 1));
  end

  assign bank_ctl.bump  = bump;
  assign bank_ctl.clear = clearing_q;

  for (genvar g = 1; g <= ORDER; g++) begin : g_bank
    localparam int unsigned AW = BYTE_W * g;
    logic [AW-1:0] push_addr;
    logic [AW-1:0] read_addr;
    logic [AW-1:0] addr;

    always_comb begin
      push_addr = '0;
      push_addr[BYTE_W-1:0] = in_byte;
      for (int unsigned j = 1; j < g; j++) begin
        push_addr[BYTE_W*j +: BYTE_W] = hist_q[j-1];
      end
      read_addr = AW'(idx_ext - region_base(g));
      addr      = in_op ? read_addr : push_addr;
    end

    bngct_bank #(
      .ADDR_W  (AW),
      .COUNT_W (COUNT_WIDTH)
    ) u_bank (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (bank_ctl),
      .addr_i     (addr),
      .clr_addr_i (clr_cnt_q[AW-1:0]),
      .count_o    (bank_cnt[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + CLR_W'(1);
      if (&clr_cnt_q) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= 2'd0;
      total_q <= '0;
      for (int unsigned j = 0; j < HIST_N; j++) begin
        hist_q[j] <= '0;
      end
    end else begin
      if (push_acc) begin
        fill_q    <= fill_d;
        hist_q[0] <= in_byte;
        for (int unsigned j = 1; j < HIST_N; j++) begin
          hist_q[j] <= hist_q[j-1];
        end
      end
      if (bump) begin
        total_q <= total_q + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_rd_q <= 1'b0;
    end else begin
      s1_rd_q <= accept & in_op;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sel_q   <= in_sel;
    s1_bad_q   <= in_bad;
    s1_total_q <= total_q;
  end

  always_comb begin
    res_cnt = s1_sel_q[0] ? s1_total_q : '0;
    for (int unsigned k = 1; k <= ORDER; k++) begin
      res_cnt = res_cnt | (s1_sel_q[k] ? bank_cnt[k] : '0);
    end
    res_val = OUT_W'(WIDE_W'(res_cnt));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (fifo_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (fifo_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= 2'(level);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_data_q[wr_ptr_q] <= res_val;
      fifo_bad_q[wr_ptr_q]  <= s1_bad_q;
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = M_TDATA_W'(fifo_data_q[rd_ptr_q]);
  assign m_axis_tuser  = fifo_bad_q[rd_ptr_q];

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> (cnt_q != 2'd2 || fifo_pop))
    else $error("read result pushed into full output buffer");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (!s_axis_tready && !m_axis_tvalid))
    else $error("request or result during table clear");

  a_bump_is_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump |=> !s1_rd_q)
    else $error("bump and read issued for the same request");

endmodule

### rtl/core/bngct_bank.sv
// One counter bank: synchronous memory with read-modify-write and write forwarding.
module bngct_bank import bngct_pkg::*; #(
  parameter int unsigned ADDR_W  = 8,
  parameter int unsigned COUNT_W = COUNT_W_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bank_ctl_t          ctl_i,
  input  logic [ADDR_W-1:0]  addr_i,
  input  logic [ADDR_W-1:0]  clr_addr_i,
  output logic [COUNT_W-1:0] count_o
);

  logic [COUNT_W-1:0] mem [2**ADDR_W];
  logic [COUNT_W-1:0] rd_data_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  logic               s1_bump_q;
  logic               fwd_vld_q;
  logic [ADDR_W-1:0]  fwd_addr_q;
  logic [COUNT_W-1:0] fwd_data_q;
  logic [COUNT_W-1:0] cur;
  logic [COUNT_W-1:0] inc;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [COUNT_W-1:0] wr_data;

  always_comb begin
    cur     = (fwd_vld_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : rd_data_q;
    inc     = cur + COUNT_W'(1);
    wr_en   = ctl_i.clear | s1_bump_q;
    wr_addr = ctl_i.clear ? clr_addr_i : s1_addr_q;
    wr_data = ctl_i.clear ? '0 : inc;
  end

  assign count_o = cur;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_bump_q <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      s1_bump_q <= ctl_i.bump;
      fwd_vld_q <= s1_bump_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= addr_i;
    fwd_addr_q <= s1_addr_q;
    fwd_data_q <= inc;
  end

endmodule
